// ===== hdl/kda_pkg.sv =====
// Shared constants and types for the key debounce and auto-repeat block.
package kda_pkg;

  // Key identity bits that are kept. Only as many as the port carries are usable.
  localparam int KEY_ID_BITS = 8;
  localparam int KEY_PORT_BITS = 8;
  localparam int KEY_BITS = (KEY_ID_BITS < KEY_PORT_BITS) ? KEY_ID_BITS : KEY_PORT_BITS;

  localparam int TICK_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRESSED_LEVEL = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_REPEAT = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [TICK_BITS-1:0] DEBOUNCE_RESET = 16'd60;
  localparam logic [TICK_BITS-1:0] FIRST_REPEAT_RESET = 16'd480;
  localparam logic [TICK_BITS-1:0] REPEAT_RESET = 16'd180;

  // Event codes.
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_FIRST_PRESS = 2'd1;
  localparam logic [1:0] EV_REPEAT = 2'd2;

  // Auto-repeat progress of the remembered key.
  localparam logic [1:0] STAGE_NONE = 2'd0;
  localparam logic [1:0] STAGE_FIRST = 2'd1;
  localparam logic [1:0] STAGE_REPEAT = 2'd2;

  typedef enum logic [2:0] {
    PHASE_IDLE     = 3'b001,
    PHASE_DEBOUNCE = 3'b010,
    PHASE_REPEAT   = 3'b100
  } phase_t;

endpackage

// ===== hdl/kda_if.sv =====
// Handshake channel interfaces: key tick input, key event output, configuration writes.
interface kda_in_if;
  logic                                valid;
  logic                                ready;
  logic [kda_pkg::KEY_PORT_BITS-1:0]   key_id;
  logic                                key_level;
  modport source (output valid, output key_id, output key_level, input ready);
  modport sink (input valid, input key_id, input key_level, output ready);
endinterface

interface kda_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          event_code;
  logic [kda_pkg::KEY_PORT_BITS-1:0]   event_key;
  modport source (output valid, output event_code, output event_key, input ready);
  modport sink (input valid, input event_code, input event_key, output ready);
endinterface

interface kda_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [kda_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [kda_pkg::CFG_DATA_BITS-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/key_debounce_autorepeat.sv =====
// Key debounce and auto-repeat: one tick per input transfer, at most one event per tick.
//
// Each input transfer is one timer tick that carries the polled key and its raw level.
// The block takes one tick every clock cycle unless a waiting event stalls it. The poll
// state and any event are both registered at the edge of the transfer, and an event
// leaves the block from its output register. A new tick is taken while that register
// is empty or is being drained in the same cycle, so the rate is one tick per cycle
// as long as the event sink keeps up. During a debounce or repeat
// wait the key identity of incoming ticks is ignored and their level is taken as the
// level of the key being polled. Configuration writes are taken at any time, but should
// only be made while no poll is in progress and no event is waiting.
module key_debounce_autorepeat (
  input  logic        clk,
  input  logic        rst,
  kda_in_if.sink      key_in,
  kda_out_if.source   event_out,
  kda_cfg_if.sink     cfg
);
  import kda_pkg::*;

  logic                 pressed_level;
  logic [TICK_BITS-1:0] debounce_ticks;
  logic [TICK_BITS-1:0] first_repeat_ticks;
  logic [TICK_BITS-1:0] repeat_ticks;

  phase_t               phase, phase_next;
  logic [TICK_BITS-1:0] wait_count, wait_count_next;
  logic [KEY_BITS-1:0]  poll_key, poll_key_next;
  logic [KEY_BITS-1:0]  held_key, held_key_next;
  logic                 held_valid, held_valid_next;
  logic [1:0]           repeat_stage, repeat_stage_next;

  logic                 out_valid;
  logic [1:0]           out_code;
  logic [KEY_PORT_BITS-1:0] out_key;

  logic                 accept;
  logic                 pressed;
  logic                 wait_over;
  logic [KEY_BITS-1:0]  tick_key;
  logic                 emit;
  logic [1:0]           emit_code;
  logic [KEY_BITS-1:0]  emit_key;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_level      <= 1'b0;
      debounce_ticks     <= DEBOUNCE_RESET;
      first_repeat_ticks <= FIRST_REPEAT_RESET;
      repeat_ticks       <= REPEAT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PRESSED_LEVEL: pressed_level      <= cfg.data[0];
        REG_DEBOUNCE:      debounce_ticks     <= cfg.data;
        REG_FIRST_REPEAT:  first_repeat_ticks <= cfg.data;
        REG_REPEAT:        repeat_ticks       <= cfg.data;
        default: ;
      endcase
    end
  end

  // The output register frees itself in the cycle it is drained.
  assign key_in.ready = !out_valid || event_out.ready;
  assign accept = key_in.valid && key_in.ready;

  assign tick_key  = key_in.key_id[KEY_BITS-1:0];
  assign pressed   = (key_in.key_level == pressed_level);
  // A wait length of zero behaves as a single tick.
  assign wait_over = (wait_count <= TICK_BITS'(1));

  always_comb begin
    phase_next        = phase;
    wait_count_next   = wait_count;
    poll_key_next     = poll_key;
    held_key_next     = held_key;
    held_valid_next   = held_valid;
    repeat_stage_next = repeat_stage;
    emit              = 1'b0;
    emit_code         = EV_NONE;
    emit_key          = poll_key;
    unique case (phase)
      PHASE_DEBOUNCE: begin
        if (!wait_over) begin
          wait_count_next = wait_count - TICK_BITS'(1);
        end else begin
          wait_count_next = '0;
          phase_next      = PHASE_IDLE;
          if (!pressed) begin
            emit = 1'b1;
          end else if (held_valid && held_key == poll_key) begin
            wait_count_next   = (repeat_stage == STAGE_FIRST) ? first_repeat_ticks
                                                              : repeat_ticks;
            repeat_stage_next = STAGE_REPEAT;
            phase_next        = PHASE_REPEAT;
          end else begin
            held_key_next     = poll_key;
            held_valid_next   = 1'b1;
            repeat_stage_next = STAGE_FIRST;
            emit              = 1'b1;
            emit_code         = EV_FIRST_PRESS;
          end
        end
      end
      PHASE_REPEAT: begin
        if (!wait_over) begin
          wait_count_next = wait_count - TICK_BITS'(1);
        end else begin
          wait_count_next = '0;
          phase_next      = PHASE_IDLE;
          emit            = 1'b1;
          if (!pressed) begin
            held_key_next     = '0;
            held_valid_next   = 1'b0;
            repeat_stage_next = STAGE_NONE;
          end else begin
            emit_code = EV_REPEAT;
          end
        end
      end
      default: begin
        phase_next = PHASE_IDLE;
        if (!pressed) begin
          emit     = 1'b1;
          emit_key = tick_key;
        end else begin
          poll_key_next   = tick_key;
          wait_count_next = debounce_ticks;
          phase_next      = PHASE_DEBOUNCE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PHASE_IDLE;
      wait_count   <= '0;
      poll_key     <= '0;
      held_key     <= '0;
      held_valid   <= 1'b0;
      repeat_stage <= STAGE_NONE;
    end else if (accept) begin
      phase        <= phase_next;
      wait_count   <= wait_count_next;
      poll_key     <= poll_key_next;
      held_key     <= held_key_next;
      held_valid   <= held_valid_next;
      repeat_stage <= repeat_stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (event_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_code <= emit_code;
      out_key  <= KEY_PORT_BITS'(emit_key);
    end
  end

  assign event_out.valid      = out_valid;
  assign event_out.event_code = out_code;
  assign event_out.event_key  = out_key;

endmodule
